// File: hw/rtl/tabulated_pair_force_interpolator_unit_defines.svh
// assertion macros for the tabulated pair force interpolator
`ifndef TABULATED_PAIR_FORCE_INTERPOLATOR_UNIT_DEFINES_SVH
`define TABULATED_PAIR_FORCE_INTERPOLATOR_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TPFI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TPFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tpfi_pkg.sv
// shared types, codes and helpers of the tabulated pair force interpolator
package tpfi_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int TABLE_PAD_DEF  = 5;

   localparam int DW         = 48;
   localparam int CW         = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TP_W       = 11;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_NEIGHBOR = 1'b1;

   localparam logic [1:0] ST_USED  = 2'd0;
   localparam logic [1:0] ST_SKIP  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_SQ   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_SCALE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_PTS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_FILTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_ANY   = 3'd4;

   localparam logic signed [DW-1:0] MAX48 = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MIN48 = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic                 op;
      logic [TP_W-1:0]      table_index;
      logic signed [DW-1:0] energy_entry;
      logic signed [DW-1:0] slope_entry;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] dz;
      logic [3:0]           neighbor_type;
      logic                 last_neighbor;
   } tpfi_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic signed [DW-1:0] pair_energy;
      logic signed [DW-1:0] neighbor_fx;
      logic signed [DW-1:0] neighbor_fy;
      logic signed [DW-1:0] neighbor_fz;
      logic signed [DW-1:0] energy_total;
      logic signed [DW-1:0] center_fx;
      logic signed [DW-1:0] center_fy;
      logic signed [DW-1:0] center_fz;
      logic                 last;
   } tpfi_rsp_type;

   // stage enables of the cubic evaluator
   typedef struct packed {
      logic coef_en;
      logic h1_en;
      logic h2_en;
      logic h3_en;
   } tpfi_cubic_ctl_type;

   function automatic logic signed [DW-1:0] sat48(input logic signed [79:0] v);
      logic signed [DW-1:0] res;
      if (v > 80'(MAX48)) res = MAX48;
      else if (v < 80'(MIN48)) res = MIN48;
      else res = v[DW-1:0];
      return res;
   endfunction

endpackage

// File: hw/rtl/tpfi_ram.sv
// generic single write port, single read port ram with registered read
module tpfi_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1029
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/tpfi_cubic.sv
// catmull-rom cubic evaluated by horner's rule, one product per stage
module tpfi_cubic
   import tpfi_pkg::*;
(
   input  logic                 clock,
   input  tpfi_cubic_ctl_type   ctl,
   input  logic signed [DW-1:0] p0,
   input  logic signed [DW-1:0] p1,
   input  logic signed [DW-1:0] p2,
   input  logic signed [DW-1:0] p3,
   input  logic [15:0]          t,
   output logic signed [DW-1:0] result
);

   localparam int IW = 56;

   logic signed [IW-1:0] c1_ff, c2_ff, c3_ff, p1_ff;
   logic signed [IW-1:0] c1_in, c2_in, c3_in;
   logic signed [IW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0] z_ff, z_in;
   logic signed [IW+16:0] prod1, prod2, prod3;
   logic signed [IW+16:0] t_ext;

   assign c1_in = IW'(p2) - IW'(p0);
   assign c2_in = (IW'(p0) <<< 1) - 5 * IW'(p1) + (IW'(p2) <<< 2) - IW'(p3);
   assign c3_in = 3 * (IW'(p1) - IW'(p2)) + IW'(p3) - IW'(p0);

   assign t_ext = (IW+17)'($signed({1'b0, t}));
   assign prod1 = (IW+17)'(c3_ff) * t_ext;
   assign prod2 = (IW+17)'(x_ff) * t_ext;
   assign prod3 = (IW+17)'(y_ff) * t_ext;

   assign x_in = c2_ff + IW'(prod1 >>> 16);
   assign y_in = c1_ff + IW'(prod2 >>> 16);
   // the halving folds into the last shift
   assign z_in = sat48(80'(p1_ff) + 80'(prod3 >>> 17));

   always_ff @(posedge clock) begin
      if (ctl.coef_en) begin
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         c3_ff <= c3_in;
         p1_ff <= IW'(p1);
      end
      if (ctl.h1_en) begin
         x_ff <= x_in;
      end
      if (ctl.h2_en) begin
         y_ff <= y_in;
      end
      if (ctl.h3_en) begin
         z_ff <= z_in;
      end
   end

   assign result = z_ff;

endmodule

// File: hw/rtl/tabulated_pair_force_interpolator_unit.sv
// Tabulated pair force interpolator: one item at a time. A table load beat goes
// straight to the result state. A neighbor beat stops after the index state when
// rejected by type, cutoff or index range, after the coefficient state when its
// energy word is zero, else runs the horner and force states. Each table's four
// reads go one a cycle through the ram's single read port; the cubic runs one horner
// product per cycle. A new beat is taken once the previous is in the output register,
// even while the response waits. Energy and slope tables hold garbage until loaded.
`include "tabulated_pair_force_interpolator_unit_defines.svh"
module tabulated_pair_force_interpolator_unit
   import tpfi_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int TABLE_PAD  = TABLE_PAD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tpfi_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tpfi_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_POINTS + TABLE_PAD;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SQ    = 4'd1;
   localparam logic [3:0] S_SCALE = 4'd2;
   localparam logic [3:0] S_IDX   = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_WAIT  = 4'd5;
   localparam logic [3:0] S_COEF  = 4'd6;
   localparam logic [3:0] S_H1    = 4'd7;
   localparam logic [3:0] S_H2    = 4'd8;
   localparam logic [3:0] S_H3    = 4'd9;
   localparam logic [3:0] S_F     = 4'd10;
   localparam logic [3:0] S_FS    = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   // configuration
   logic [31:0]     cutoff_sq_ff, index_scale_ff;
   logic [TP_W-1:0] table_points_ff;
   logic [3:0]      type_filter_ff;
   logic            match_any_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_sq_ff    <= '0;
         index_scale_ff  <= '0;
         table_points_ff <= TP_W'(1024);
         type_filter_ff  <= '0;
         match_any_ff    <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CUTOFF_SQ:   cutoff_sq_ff    <= csr_wdata;
            CSR_INDEX_SCALE: index_scale_ff  <= csr_wdata;
            CSR_TABLE_PTS:   table_points_ff <= csr_wdata[TP_W-1:0];
            CSR_TYPE_FILTER: type_filter_ff  <= csr_wdata[3:0];
            CSR_MATCH_ANY:   match_any_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [3:0]  state_ff, state_in;
   logic [1:0]  status_ff, status_in;
   logic [1:0]  rd_cnt_ff, rd_slot_ff;
   logic        cap_ff;
   logic        pass_ff;
   logic        rsp_valid_ff;
   tpfi_req_type item_ff;
   tpfi_rsp_type rsp_ff, rsp_in;

   logic [62:0] sq_ff [3];
   logic [63:0] p_hi_ff, p_hi_in;
   logic [63:0] p_lo_ff, p_lo_in;
   logic [63:0] rsq;
   logic        in_cut;
   logic [63:0] r;
   logic [47:0] m, lim;
   logic [15:0] t_ff;
   logic [AW-1:0] base_ff, raddr;
   logic signed [DW-1:0] ep_ff [4];
   logic signed [DW-1:0] sp_ff [4];
   logic [DW-1:0] e_rdata, s_rdata;
   logic signed [DW-1:0] pe, de;
   logic signed [CW-1:0] d_sel [3];
   logic signed [63:0] ph_ff [3];
   logic signed [64:0] pl_ff [3];
   logic signed [DW-1:0] nf_ff [3];
   logic signed [DW-1:0] es_ff, es_in;
   logic signed [DW-1:0] cf_ff [3];
   logic signed [DW-1:0] cf_in [3];
   logic signed [DW-1:0] cf_new [3];
   logic signed [DW-1:0] es_new;
   logic        accept, out_free, table_we;
   logic [31:0] idx_ext;
   tpfi_cubic_ctl_type cubic_ctl;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_ext   = {21'b0, req_data.table_index};
   assign table_we  = accept && (req_data.op == OP_LOAD) && (idx_ext < 32'(DEPTH));

   assign d_sel[0] = item_ff.dx;
   assign d_sel[1] = item_ff.dy;
   assign d_sel[2] = item_ff.dz;

   // distance and table index arithmetic
   assign rsq     = 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
   assign in_cut  = rsq <= {16'b0, cutoff_sq_ff, 16'b0};
   assign p_hi_in = 64'(rsq[63:32]) * 64'(index_scale_ff);
   assign p_lo_in = 64'(rsq[31:0]) * 64'(index_scale_ff);
   assign r       = p_hi_ff + 64'(p_lo_ff[63:32]);
   assign m       = r[63:16];
   assign lim     = (48'(table_points_ff) > 48'(MAX_POINTS)) ? 48'(MAX_POINTS)
                                                             : 48'(table_points_ff);
   assign raddr   = base_ff + AW'(rd_cnt_ff);

   tpfi_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_energy_ram (
      .clock (clock),
      .we    (table_we),
      .waddr (idx_ext[AW-1:0]),
      .wdata (req_data.energy_entry),
      .raddr (raddr),
      .rdata (e_rdata)
   );

   tpfi_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_slope_ram (
      .clock (clock),
      .we    (table_we),
      .waddr (idx_ext[AW-1:0]),
      .wdata (req_data.slope_entry),
      .raddr (raddr),
      .rdata (s_rdata)
   );

   assign cubic_ctl.coef_en = (state_ff == S_COEF);
   assign cubic_ctl.h1_en   = (state_ff == S_H1);
   assign cubic_ctl.h2_en   = (state_ff == S_H2);
   assign cubic_ctl.h3_en   = (state_ff == S_H3);

   tpfi_cubic u_energy_cubic (
      .clock  (clock),
      .ctl    (cubic_ctl),
      .p0     (ep_ff[0]),
      .p1     (ep_ff[1]),
      .p2     (ep_ff[2]),
      .p3     (ep_ff[3]),
      .t      (t_ff),
      .result (pe)
   );

   tpfi_cubic u_slope_cubic (
      .clock  (clock),
      .ctl    (cubic_ctl),
      .p0     (sp_ff[0]),
      .p1     (sp_ff[1]),
      .p2     (sp_ff[2]),
      .p3     (sp_ff[3]),
      .t      (t_ff),
      .result (de)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_LOAD) begin
                  state_in  = S_DONE;
                  status_in = ST_WRITE;
               end else begin
                  state_in = S_SQ;
               end
            end
         end
         S_SQ:    state_in = S_SCALE;
         S_SCALE: state_in = S_IDX;
         S_IDX: begin
            if (!pass_ff) begin
               state_in  = S_DONE;
               status_in = ST_SKIP;
            end else if (m < 48'd1 || m > lim) begin
               state_in  = S_DONE;
               status_in = ST_ERROR;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (rd_cnt_ff == 2'd3) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_COEF;
         S_COEF: begin
            if (ep_ff[1] == '0) begin
               state_in  = S_DONE;
               status_in = ST_SKIP;
            end else begin
               state_in = S_H1;
            end
         end
         S_H1: state_in = S_H2;
         S_H2: state_in = S_H3;
         S_H3: state_in = S_F;
         S_F:  state_in = S_FS;
         S_FS: begin
            state_in  = S_DONE;
            status_in = ST_USED;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // accumulate and build the response beat
   always_comb begin
      es_new = (status_ff == ST_USED) ? sat48(80'(es_ff) + 80'(pe)) : es_ff;
      for (int k = 0; k < 3; k++) begin
         cf_new[k] = (status_ff == ST_USED) ? sat48(80'(cf_ff[k]) - 80'(nf_ff[k]))
                                            : cf_ff[k];
      end
      rsp_in = '0;
      rsp_in.status = status_ff;
      if (status_ff != ST_WRITE) begin
         if (status_ff == ST_USED) begin
            rsp_in.pair_energy = pe;
            rsp_in.neighbor_fx = nf_ff[0];
            rsp_in.neighbor_fy = nf_ff[1];
            rsp_in.neighbor_fz = nf_ff[2];
         end
         rsp_in.energy_total = es_new;
         rsp_in.center_fx    = cf_new[0];
         rsp_in.center_fy    = cf_new[1];
         rsp_in.center_fz    = cf_new[2];
         rsp_in.last         = item_ff.last_neighbor;
      end
      if (status_ff != ST_WRITE && item_ff.last_neighbor) begin
         es_in = '0;
         for (int k = 0; k < 3; k++) cf_in[k] = '0;
      end else begin
         es_in = es_new;
         for (int k = 0; k < 3; k++) cf_in[k] = cf_new[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 1'b0;
         rd_cnt_ff    <= '0;
         es_ff        <= '0;
         for (int k = 0; k < 3; k++) cf_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= (state_ff == S_RD);
         if (state_ff == S_RD) begin
            rd_cnt_ff <= rd_cnt_ff + 2'd1;
         end else begin
            rd_cnt_ff <= '0;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            es_ff        <= es_in;
            for (int k = 0; k < 3; k++) cf_ff[k] <= cf_in[k];
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      rd_slot_ff <= rd_cnt_ff;
      if (accept) begin
         item_ff <= req_data;
      end
      if (state_ff == S_SQ) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= 63'(64'(d_sel[k]) * 64'(d_sel[k]));
         end
         pass_ff <= match_any_ff || (item_ff.neighbor_type == type_filter_ff);
      end
      if (state_ff == S_SCALE) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         pass_ff <= pass_ff && in_cut;
      end
      if (state_ff == S_IDX) begin
         t_ff    <= r[15:0];
         base_ff <= AW'(m - 48'd1);
      end
      if (cap_ff) begin
         ep_ff[rd_slot_ff] <= e_rdata;
         sp_ff[rd_slot_ff] <= s_rdata;
      end
      if (state_ff == S_F) begin
         for (int k = 0; k < 3; k++) begin
            ph_ff[k] <= 64'(de) * 64'($signed(d_sel[k][31:16]));
            pl_ff[k] <= 65'(de) * 65'($signed({1'b0, d_sel[k][15:0]}));
         end
      end
      if (state_ff == S_FS) begin
         for (int k = 0; k < 3; k++) begin
            nf_ff[k] <= sat48(80'(ph_ff[k]) + 80'(pl_ff[k] >>> 16));
         end
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TPFI_ASSERT_NEXT(a_load_to_done, clock, reset,
      accept && req_data.op == OP_LOAD, state_ff == S_DONE && status_ff == ST_WRITE,
      "table load beat did not go straight to the result stage")
   `TPFI_ASSERT_NOW(a_write_beat_zero, clock, reset,
      rsp_valid && rsp_data.status == ST_WRITE,
      rsp_data.energy_total == '0 && rsp_data.center_fx == '0 && rsp_data.last == 1'b0,
      "table write beat carries nonzero sums")
   `TPFI_ASSERT_NEXT(a_last_clears, clock, reset,
      state_ff == S_DONE && out_free && status_ff != ST_WRITE && item_ff.last_neighbor,
      es_ff == '0 && cf_ff[0] == '0 && cf_ff[1] == '0 && cf_ff[2] == '0,
      "sums not cleared after last neighbor")

endmodule
